### rtl/homoglyph_bit_embed_extract_defines.svh
`ifndef HOMOGLYPH_BIT_EMBED_EXTRACT_DEFINES_SVH
`define HOMOGLYPH_BIT_EMBED_EXTRACT_DEFINES_SVH

// same-cycle implication, checked on clk, quiet while in reset
`define HGBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgbe check failed");

// next-cycle implication, checked on clk, quiet while in reset
`define HGBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgbe check failed");

`endif

### rtl/hgbe_pkg.sv
`timescale 1ns / 1ps

package hgbe_pkg;

    localparam int CHAR_W     = 16;
    localparam int PAIR_COUNT = 18;

    // item kind codes on the input side
    localparam logic [1:0] KIND_MSG  = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // mode register codes
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // look-alike pairs: cyrillic form and latin form at the same index
    localparam logic [CHAR_W-1:0] CYR_FORM [PAIR_COUNT] = '{
        16'h0410, 16'h0430, 16'h0412, 16'h0415, 16'h0435, 16'h041A,
        16'h041C, 16'h041D, 16'h041E, 16'h043E, 16'h0420, 16'h0440,
        16'h0421, 16'h0441, 16'h0422, 16'h0443, 16'h0425, 16'h0445
    };
    localparam logic [CHAR_W-1:0] LAT_FORM [PAIR_COUNT] = '{
        16'h0041, 16'h0061, 16'h0042, 16'h0045, 16'h0065, 16'h004B,
        16'h004D, 16'h0048, 16'h004F, 16'h006F, 16'h0050, 16'h0070,
        16'h0043, 16'h0063, 16'h0054, 16'h0079, 16'h0058, 16'h0078
    };

    typedef struct packed {
        logic              hit;
        logic              is_cyr;
        logic [CHAR_W-1:0] cyr;
        logic [CHAR_W-1:0] lat;
    } pair_t;

    // middle stage of the pipeline, one item waiting for its message word
    typedef struct packed {
        logic              sub;
        logic [3:0]        bit_sh;
        logic [CHAR_W-1:0] cyr;
        logic [CHAR_W-1:0] lat;
        logic [CHAR_W-1:0] ch;
        logic              is_status;
        logic              short_cap;
        logic              overflow;
    } s1_t;

    // carrier lookup over the pair table, all compares side by side
    function automatic pair_t find_pair(input logic [CHAR_W-1:0] c);
        pair_t r;
        r = '0;
        for (int i = 0; i < PAIR_COUNT; i++)
        begin
            if (!r.hit && (CYR_FORM[i] == c || LAT_FORM[i] == c))
            begin
                r.hit    = 1'b1;
                r.is_cyr = (CYR_FORM[i] == c);
                r.cyr    = CYR_FORM[i];
                r.lat    = LAT_FORM[i];
            end
        end
        return r;
    endfunction

endpackage

### rtl/homoglyph_bit_embed_extract.sv
`timescale 1ns / 1ps
// Homoglyph bit embed and extract. A stream of items enters on s_axis (tuser kind: message
// character, text character or end of text; tdata the 16-bit code). Message characters are
// kept in an on-chip buffer of MSG_CHARS words. With mode 0 every text character gives one
// result item: a carrier letter, while message bits remain, leaves as its cyrillic form for a
// bit of 1 or its latin form for 0, MSB first; anything else passes unchanged. With mode 1
// carrier letters are gathered into 16-bit characters and each nonzero one is sent out. End of
// text gives a status item (tuser set) with the short-capacity and overflow flags and clears
// the block for the next message. One item is taken every cycle while the output is not
// stalled; each passes a two-register pipeline (message buffer read, then output register).
// The buffer's single read port and single write port serve one item per cycle. The user must
// write mode on the cfg channel only while the block is idle; the block does not enforce this.
`include "homoglyph_bit_embed_extract_defines.svh"

module homoglyph_bit_embed_extract #(
    parameter int MSG_CHARS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: mode register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] out_char, [16] short_capacity,
                                        // [17] msg_overflow, [23:18] zero
    output logic        m_axis_tuser    // [0] is_status
);

    localparam int AW = (MSG_CHARS > 1) ? $clog2(MSG_CHARS) : 1;
    localparam int LW = $clog2(MSG_CHARS + 1);
    localparam int BW = LW + 4;
    localparam logic [LW-1:0] LEN_MAX = LW'(MSG_CHARS);

    // message buffer
    logic [15:0] mem [MSG_CHARS];
    logic [15:0] rd_data_reg;

    // control state
    logic          mode_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [BW-1:0] pos_reg, pos_next;
    logic [15:0]   gshift_reg, gshift_next;
    logic [3:0]    gcount_reg, gcount_next;
    logic          ovf_reg, ovf_next;

    // pipeline
    logic         s1_valid_reg, s1_valid_next;
    hgbe_pkg::s1_t s1_reg, s1_next;
    logic         out_valid_reg;
    logic [15:0]  out_char_reg;
    logic         out_status_reg, out_short_reg, out_ovf_reg;

    logic          in_acc, s1_go, has_bits, produce, wr_en, rd_en;
    logic [15:0]   shifted;
    hgbe_pkg::pair_t pair;

    assign cfg_ready     = 1'b1;
    assign s1_go         = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign pair     = hgbe_pkg::find_pair(s_axis_tdata);
    assign has_bits = pos_reg < {len_reg, 4'b0000};
    assign shifted  = {gshift_reg[14:0], pair.is_cyr};

    // per-item state update and middle stage contents
    always_comb
    begin
        len_next    = len_reg;
        pos_next    = pos_reg;
        gshift_next = gshift_reg;
        gcount_next = gcount_reg;
        ovf_next    = ovf_reg;
        produce     = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        s1_next     = '0;
        s1_next.bit_sh = ~pos_reg[3:0];
        s1_next.cyr    = pair.cyr;
        s1_next.lat    = pair.lat;
        s1_next.ch     = s_axis_tdata;
        if (in_acc)
        begin
            case (s_axis_tuser)
                hgbe_pkg::KIND_MSG:
                begin
                    if (len_reg < LEN_MAX)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                hgbe_pkg::KIND_TEXT:
                begin
                    if (mode_reg == hgbe_pkg::MODE_EMBED)
                    begin
                        produce = 1'b1;
                        if (pair.hit && has_bits)
                        begin
                            s1_next.sub = 1'b1;
                            rd_en       = 1'b1;
                            pos_next    = pos_reg + 1'b1;
                        end
                    end
                    else if (pair.hit)
                    begin
                        if (gcount_reg == 4'd15)
                        begin
                            gcount_next = 4'd0;
                            gshift_next = '0;
                            s1_next.ch  = shifted;
                            produce     = (shifted != 16'd0);
                        end
                        else
                        begin
                            gcount_next = gcount_reg + 1'b1;
                            gshift_next = shifted;
                        end
                    end
                end
                hgbe_pkg::KIND_END:
                begin
                    produce           = 1'b1;
                    s1_next.ch        = '0;
                    s1_next.is_status = 1'b1;
                    s1_next.short_cap = (mode_reg == hgbe_pkg::MODE_EMBED) && has_bits;
                    s1_next.overflow  = ovf_reg;
                    len_next    = '0;
                    pos_next    = '0;
                    gshift_next = '0;
                    gcount_next = '0;
                    ovf_next    = 1'b0;
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end
    end

    // middle stage occupancy
    always_comb
    begin
        if (in_acc)
            s1_valid_next = produce;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // buffer write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[len_reg[AW-1:0]] <= s_axis_tdata;
        if (rd_en)
            rd_data_reg <= mem[pos_reg[AW+3:4]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= hgbe_pkg::MODE_EMBED;
            len_reg       <= '0;
            pos_reg       <= '0;
            gshift_reg    <= '0;
            gcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            gshift_reg   <= gshift_next;
            gcount_reg   <= gcount_next;
            ovf_reg      <= ovf_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_go)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers of both stages
    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_reg <= s1_next;
        if (s1_go && s1_valid_reg)
        begin
            if (s1_reg.sub)
                out_char_reg <= rd_data_reg[s1_reg.bit_sh] ? s1_reg.cyr : s1_reg.lat;
            else
                out_char_reg <= s1_reg.ch;
            out_status_reg <= s1_reg.is_status;
            out_short_reg  <= s1_reg.short_cap;
            out_ovf_reg    <= s1_reg.overflow;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_ovf_reg, out_short_reg, out_char_reg};
    assign m_axis_tuser  = out_status_reg;

    // checks
    `HGBE_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_MAX)
    `HGBE_ASSERT_NOW(a_pos_bound, 1'b1, pos_reg <= {len_reg, 4'b0000})
    `HGBE_ASSERT_NEXT(a_end_clears,
        in_acc && s_axis_tuser == hgbe_pkg::KIND_END,
        len_reg == '0 && pos_reg == '0 && gcount_reg == 4'd0 && !ovf_reg)
    `HGBE_ASSERT_NOW(a_no_overrun,
        s1_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready)

endmodule

### sim/tb_homoglyph_bit_embed_extract.sv
`timescale 1ns / 1ps

module tb_homoglyph_bit_embed_extract;

    localparam int MSG_DEPTH    = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 1700;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] glyph;
        logic        status;
        logic        short_cap;
        logic        overflow;
    } glyph_result_t;

    // mirror of the embed/extract state and the queue of awaited results
    class glyph_scoreboard;
        logic              mode;
        logic [15:0]       store [MSG_DEPTH];
        int                msg_len;
        int                bit_pos;
        logic [15:0]       gather;
        int                gather_count;
        logic              ovf;
        glyph_result_t     awaited [$];
        int                errors;

        function new();
            mode = hgbe_pkg::MODE_EMBED;
            msg_len = 0;
            bit_pos = 0;
            gather = '0;
            gather_count = 0;
            ovf = 1'b0;
            errors = 0;
        endfunction

        // pair index of a carrier letter, or -1; cyr tells which form matched
        function int pair_of(logic [15:0] c, output logic cyr);
            cyr = 1'b0;
            for (int i = 0; i < hgbe_pkg::PAIR_COUNT; i++)
            begin
                if (hgbe_pkg::CYR_FORM[i] == c)
                begin
                    cyr = 1'b1;
                    return i;
                end
                if (hgbe_pkg::LAT_FORM[i] == c)
                    return i;
            end
            return -1;
        endfunction

        function void push_result(logic [15:0] glyph, logic status, logic short_cap,
                                  logic overflow);
            glyph_result_t r;
            r.glyph = glyph;
            r.status = status;
            r.short_cap = short_cap;
            r.overflow = overflow;
            awaited.push_back(r);
        endfunction

        // work out what one accepted input item should produce
        function void note_item(logic [1:0] kind, logic [15:0] code);
            int          p;
            logic        cyr;
            logic [15:0] ch;
            logic [15:0] word;
            case (kind)
                hgbe_pkg::KIND_MSG:
                begin
                    if (msg_len < MSG_DEPTH)
                    begin
                        store[msg_len] = code;
                        msg_len++;
                    end
                    else
                        ovf = 1'b1;
                end
                hgbe_pkg::KIND_TEXT:
                begin
                    p = pair_of(code, cyr);
                    if (mode == hgbe_pkg::MODE_EMBED)
                    begin
                        ch = code;
                        if (p >= 0 && bit_pos < msg_len * 16)
                        begin
                            word = store[bit_pos / 16];
                            ch = word[15 - (bit_pos % 16)] ? hgbe_pkg::CYR_FORM[p]
                                                           : hgbe_pkg::LAT_FORM[p];
                            bit_pos++;
                        end
                        push_result(ch, 1'b0, 1'b0, 1'b0);
                    end
                    else if (p >= 0)
                    begin
                        gather = {gather[14:0], cyr};
                        gather_count++;
                        if (gather_count == 16)
                        begin
                            gather_count = 0;
                            if (gather != 16'h0000)
                                push_result(gather, 1'b0, 1'b0, 1'b0);
                            gather = '0;
                        end
                    end
                end
                hgbe_pkg::KIND_END:
                begin
                    push_result(16'h0000, 1'b1,
                                (mode == hgbe_pkg::MODE_EMBED) && (bit_pos < msg_len * 16),
                                ovf);
                    msg_len = 0;
                    bit_pos = 0;
                    gather = '0;
                    gather_count = 0;
                    ovf = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // compare one accepted result with the oldest awaited one
        function void check_result(logic [15:0] glyph, logic status, logic short_cap,
                                   logic overflow);
            glyph_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: out_char %h is_status %b", glyph, status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (want.glyph !== glyph)
            begin
                $error("out_char expected %h actual %h", want.glyph, glyph);
                errors++;
            end
            if (want.status !== status)
            begin
                $error("is_status expected %b actual %b", want.status, status);
                errors++;
            end
            if (want.short_cap !== short_cap)
            begin
                $error("short_capacity expected %b actual %b", want.short_cap, short_cap);
                errors++;
            end
            if (want.overflow !== overflow)
            begin
                $error("msg_overflow expected %b actual %b", want.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] code
    logic [1:0]  s_axis_tuser = '0;     // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] out_char, [16] short_capacity,
                                        // [17] msg_overflow
    logic        m_axis_tuser;          // [0] is_status

    glyph_scoreboard sb = new();
    int items_sent = 0;
    int cycle_count = 0;
    int send_run = 0;
    int recv_run = 0;

    homoglyph_bit_embed_extract dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // wait cycles for one item, with occasional stretches of none
    function automatic int draw_gap(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // random code with the extremes turning up now and then
    function automatic logic [15:0] rand_code();
        case ($urandom_range(0, 15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [15:0] code);
        int gap;
        gap = draw_gap(send_run);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= code;
        s_axis_tuser <= kind;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(kind, code);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic send_carrier(input logic hidden_bit);
        int idx;
        idx = $urandom_range(0, hgbe_pkg::PAIR_COUNT - 1);
        send_item(hgbe_pkg::KIND_TEXT,
                  hidden_bit ? hgbe_pkg::CYR_FORM[idx] : hgbe_pkg::LAT_FORM[idx]);
    endtask

    // mode written only once the block has drained
    task automatic write_mode(input logic m);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        sb.mode = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // embed: buffer a message, then a text with carriers and plain letters
    task automatic embed_phase();
        int n_msg;
        int n_text;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            n_msg = $urandom_range(60, 70);
        else if (pick < 3)
            n_msg = $urandom_range(5, 8);
        else
            n_msg = $urandom_range(0, 3);
        for (int i = 0; i < n_msg; i++)
            send_item(hgbe_pkg::KIND_MSG, rand_code());
        n_text = $urandom_range(0, (n_msg > 8) ? 40 : n_msg * 16 + 12);
        for (int i = 0; i < n_text; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(KIND_UNUSED, rand_code());
            if ($urandom_range(0, 9) < 7)
                send_carrier(1'($urandom_range(0, 1)));
            else
                send_item(hgbe_pkg::KIND_TEXT, rand_code());
        end
        if ($urandom_range(0, 9) != 0)
            send_item(hgbe_pkg::KIND_END, rand_code());
    endtask

    // extract: carriers spelling hidden characters, some cut short
    task automatic extract_phase();
        int          n_chars;
        int          n_bits;
        logic [15:0] hidden;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_item(hgbe_pkg::KIND_MSG, rand_code());
        n_chars = $urandom_range(1, 4);
        for (int c = 0; c < n_chars; c++)
        begin
            hidden = ($urandom_range(0, 7) == 0) ? 16'h0000 : rand_code();
            n_bits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
            for (int b = 15; b >= 16 - n_bits; b--)
            begin
                if ($urandom_range(0, 9) < 3)
                    send_item(hgbe_pkg::KIND_TEXT, rand_code());
                if ($urandom_range(0, 39) == 0)
                    send_item(KIND_UNUSED, rand_code());
                send_carrier(hidden[b]);
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_item(hgbe_pkg::KIND_END, rand_code());
    endtask

    // result side: random stalls per item
    initial
    begin
        int stall;
        forever
        begin
            stall = draw_gap(recv_run);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[16],
                            m_axis_tdata[17]);
    end

    // stimulus
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // embed with both code extremes, plain letters and an ignored kind
        write_mode(hgbe_pkg::MODE_EMBED);
        send_item(hgbe_pkg::KIND_MSG, 16'hFFFF);
        send_item(hgbe_pkg::KIND_MSG, 16'h0000);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0041);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0000);
        send_item(hgbe_pkg::KIND_TEXT, 16'hFFFF);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0445);
        send_item(KIND_UNUSED, 16'h5A5A);
        send_item(hgbe_pkg::KIND_END, 16'hFFFF);

        // extract with a partial character dropped at end of text
        write_mode(hgbe_pkg::MODE_EXTRACT);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0410);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0041);
        send_item(hgbe_pkg::KIND_TEXT, 16'h1234);
        send_item(hgbe_pkg::KIND_MSG, 16'h8001);
        send_item(hgbe_pkg::KIND_END, 16'h0000);

        // mode flipped in the middle of a text, state carried over
        write_mode(hgbe_pkg::MODE_EMBED);
        send_item(hgbe_pkg::KIND_MSG, 16'h8000);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0041);
        write_mode(hgbe_pkg::MODE_EXTRACT);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0430);
        write_mode(hgbe_pkg::MODE_EMBED);
        send_item(hgbe_pkg::KIND_TEXT, 16'h0061);
        send_item(hgbe_pkg::KIND_END, 16'h0000);

        // random phases, each under a freshly written mode
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                write_mode(hgbe_pkg::MODE_EMBED);
                embed_phase();
            end
            else
            begin
                write_mode(hgbe_pkg::MODE_EXTRACT);
                extract_phase();
            end
        end

        // drain
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/hgbe_pkg.sv
rtl/homoglyph_bit_embed_extract.sv
sim/tb_homoglyph_bit_embed_extract.sv
